>>> hdl/fac_pkg.sv
// Shared types and constants for the float accumulator calculator
`timescale 1ns / 1ps
`default_nettype none
package fac_pkg;
    typedef enum logic [2:0] {
        CMD_LOAD = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_SQRT = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_DIV0 = 2'd1,
        ERR_SQRT = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ITER,
        ST_ROUND,
        ST_OUT,
        ST_WB
    } state_t;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_MUL  = 2'd1,
        OP_DIV  = 2'd2,
        OP_SQRT = 2'd3
    } op_t;

    typedef struct packed {
        logic start;
        logic prep;
        logic iter;
        logic round;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic special;
        logic iter_done;
    } dp_stat_t;

    localparam logic [31:0] CANON_NAN = 32'h7FC00000;
    localparam int          ITER_N    = 27;
endpackage
`default_nettype wire

>>> hdl/fac_datapath.sv
// Arithmetic datapath: unpack, add, multiply, iterative divide and square root, round and pack
`timescale 1ns / 1ps
`default_nettype none
module fac_datapath (
    input  wire logic            aclk,
    input  wire fac_pkg::dp_cmd_t cmd,
    input  wire logic [31:0]     a_in,
    input  wire logic [31:0]     b_in,
    output fac_pkg::dp_stat_t    stat,
    output logic [31:0]          result
);
    import fac_pkg::*;

    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [9:0]  ea_u, eb_u;
    logic [23:0] ma, mb;

    assign sa = a_in[31]; assign ea = a_in[30:23]; assign fa = a_in[22:0];
    assign sb = b_in[31]; assign eb = b_in[30:23]; assign fb = b_in[22:0];
    assign a_nan = (ea == 8'hFF) && (fa != 0);
    assign b_nan = (eb == 8'hFF) && (fb != 0);
    assign a_inf = (ea == 8'hFF) && (fa == 0);
    assign b_inf = (eb == 8'hFF) && (fb == 0);
    assign a_zero = (a_in[30:0] == 0);
    assign b_zero = (b_in[30:0] == 0);
    assign ma = {(ea != 0), fa};
    assign mb = {(eb != 0), fb};
    assign ea_u = (ea == 0) ? 10'd1 : {2'b0, ea};
    assign eb_u = (eb == 0) ? 10'd1 : {2'b0, eb};

    // Working registers
    logic        special_reg, special_next;
    logic [31:0] spec_val_reg, spec_val_next;
    logic        sign_reg, sign_next;
    logic signed [11:0] exp_reg, exp_next;
    logic [49:0] mant_reg, mant_next;
    logic [49:0] rem_reg, rem_next;
    logic [49:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [5:0]  nrm_reg, nrm_next;
    logic [31:0] res_reg, res_next;

    // Normalise a 24-bit significand by leading-zero count (subnormals)
    function automatic logic [4:0] lz24(input logic [23:0] m);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    logic [4:0]  lza, lzb;
    logic [23:0] mna, mnb;
    logic signed [11:0] xa, xb;
    assign lza = lz24(ma);
    assign lzb = lz24(mb);
    assign mna = ma << lza;
    assign mnb = mb << lzb;
    assign xa = $signed({2'b0, ea_u}) - 12'sd127 - $signed({7'b0, lza});
    assign xb = $signed({2'b0, eb_u}) - 12'sd127 - $signed({7'b0, lzb});

    // Addition alignment
    logic        a_big;
    logic [9:0]  ediff;
    logic [49:0] add_big, add_sml, add_sum;
    logic        add_sticky;
    logic [49:0] sml_full;
    logic [9:0]  sh;
    always_comb begin
        a_big = (a_in[30:0] >= b_in[30:0]);
        ediff = a_big ? (ea_u - eb_u) : (eb_u - ea_u);
        add_big = a_big ? {1'b0, ma, 25'b0} : {1'b0, mb, 25'b0};
        sml_full = a_big ? {1'b0, mb, 25'b0} : {1'b0, ma, 25'b0};
        sh = (ediff > 10'd49) ? 10'd49 : ediff;
        add_sml = sml_full >> sh;
        add_sticky = ((add_sml << sh) != sml_full);
        add_sml[0] = add_sml[0] | add_sticky;
        if (sa == sb) begin
            add_sum = add_big + add_sml;
        end else begin
            add_sum = add_big - add_sml;
        end
    end

    logic [47:0] prod;
    assign prod = mna * mnb;

    // Square root step
    logic signed [11:0] sq_e;
    logic [49:0] sq_m;
    always_comb begin
        if (xa[0]) begin
            sq_e = xa - 12'sd1;
            sq_m = {25'b0, mna, 1'b0} << 23;
        end else begin
            sq_e = xa;
            sq_m = {26'b0, mna} << 23;
        end
    end

    // Iteration: restoring division / digit-by-digit root
    logic [49:0] trial;
    logic [49:0] sq_rem_sh;
    logic [49:0] sq_trial;
    always_comb begin
        trial = {rem_reg[48:0], 1'b0};
        sq_rem_sh = {rem_reg[47:0], den_reg[49:48]};
        sq_trial = {mant_reg[47:0], 2'b01};
    end

    // Rounding
    logic [49:0] rnd_m;
    logic signed [11:0] rnd_e;
    logic [5:0]  msb;
    logic signed [11:0] e_adj;
    logic [49:0] norm;
    logic [9:0]  dn;
    logic [49:0] dn_m;
    logic        stk;
    logic [24:0] kept;
    logic [25:0] rounded;
    logic [31:0] packed_v;

    function automatic logic [5:0] msb50(input logic [49:0] m);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (m[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    assign msb = nrm_reg;

    always_comb begin
        rnd_m = mant_reg;
        rnd_e = exp_reg;
        // place leading one at bit 49
        norm = rnd_m << (6'd49 - msb);
        e_adj = rnd_e + $signed({6'b0, msb});
        dn = 10'd0;
        if (e_adj < -12'sd126) begin
            dn = ((-12'sd126 - e_adj) > 12'sd40) ? 10'd40 : 10'(-12'sd126 - e_adj);
            e_adj = -12'sd126;
        end
        dn_m = norm >> dn;
        stk = ((dn_m << dn) != norm) || (dn_m[24:0] != 0);
        kept = dn_m[49:25];
        rounded = {1'b0, kept[24:1]} +
                  26'(kept[0] && (stk || kept[1]));
        packed_v = {sign_reg, 31'b0};
        if (rounded[24]) begin
            if (e_adj + 12'sd1 > 12'sd127) begin
                packed_v = {sign_reg, 8'hFF, 23'b0};
            end else begin
                packed_v = {sign_reg, 8'(e_adj + 12'sd128), rounded[22:0]};
            end
        end else if (rounded[23]) begin
            if (e_adj > 12'sd127) begin
                packed_v = {sign_reg, 8'hFF, 23'b0};
            end else begin
                packed_v = {sign_reg, 8'(e_adj + 12'sd127), rounded[22:0]};
            end
        end else begin
            packed_v = {sign_reg, 8'h00, rounded[22:0]};
        end
        if (mant_reg == 0) begin
            packed_v = {sign_reg, 31'b0};
        end
    end

    always_comb begin
        special_next = special_reg;
        spec_val_next = spec_val_reg;
        sign_next = sign_reg;
        exp_next = exp_reg;
        mant_next = mant_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        nrm_next = nrm_reg;
        res_next = res_reg;
        if (cmd.start) begin
            special_next = 1'b0;
            spec_val_next = 32'b0;
            cnt_next = 5'd0;
            case (cmd.op)
                OP_ADD: begin
                    if (a_nan || b_nan || (a_inf && b_inf && sa != sb)) begin
                        special_next = 1'b1; spec_val_next = CANON_NAN;
                    end else if (a_inf) begin
                        special_next = 1'b1; spec_val_next = a_in;
                    end else if (b_inf) begin
                        special_next = 1'b1; spec_val_next = b_in;
                    end else if (a_zero && b_zero) begin
                        special_next = 1'b1; spec_val_next = {sa & sb, 31'b0};
                    end
                    sign_next = a_big ? sa : sb;
                    exp_next = $signed({2'b0, (a_big ? ea_u : eb_u)}) - 12'sd127 - 12'sd48;
                    mant_next = add_sum;
                    if (add_sum == 0 && !special_next) begin
                        special_next = 1'b1; spec_val_next = 32'b0;
                    end
                end
                OP_MUL: begin
                    sign_next = sa ^ sb;
                    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
                        special_next = 1'b1; spec_val_next = CANON_NAN;
                    end else if (a_inf || b_inf) begin
                        special_next = 1'b1; spec_val_next = {sa ^ sb, 8'hFF, 23'b0};
                    end else if (a_zero || b_zero) begin
                        special_next = 1'b1; spec_val_next = {sa ^ sb, 31'b0};
                    end
                    exp_next = xa + xb - 12'sd48;
                    mant_next = {prod, 2'b0};
                end
                OP_DIV: begin
                    sign_next = sa ^ sb;
                    if (a_nan || b_nan || (a_inf && b_inf)) begin
                        special_next = 1'b1; spec_val_next = CANON_NAN;
                    end else if (a_inf) begin
                        special_next = 1'b1; spec_val_next = {sa ^ sb, 8'hFF, 23'b0};
                    end else if (b_inf || a_zero) begin
                        special_next = 1'b1; spec_val_next = {sa ^ sb, 31'b0};
                    end
                    exp_next = xa - xb - 12'sd26;
                    mant_next = 50'b0;
                    rem_next = {26'b0, mna};
                    den_next = {26'b0, mnb};
                end
                OP_SQRT: begin
                    sign_next = 1'b0;
                    if (a_nan) begin
                        special_next = 1'b1; spec_val_next = CANON_NAN;
                    end else if (a_inf || a_zero) begin
                        special_next = 1'b1; spec_val_next = a_in;
                    end
                    exp_next = (sq_e >>> 1) - 12'sd24;
                    mant_next = 50'b0;
                    rem_next = 50'b0;
                    den_next = sq_m;
                end
                default: begin
                end
            endcase
        end else if (cmd.iter) begin
            cnt_next = cnt_reg + 5'd1;
            if (cmd.op == OP_DIV) begin
                if (rem_reg >= den_reg) begin
                    rem_next = {rem_reg[48:0] - den_reg[48:0], 1'b0};
                    mant_next = {mant_reg[48:0], 1'b1};
                end else begin
                    rem_next = trial;
                    mant_next = {mant_reg[48:0], 1'b0};
                end
            end else begin
                den_next = {den_reg[47:0], 2'b00};
                if (sq_rem_sh >= sq_trial) begin
                    rem_next = sq_rem_sh - sq_trial;
                    mant_next = {mant_reg[48:0], 1'b1};
                end else begin
                    rem_next = sq_rem_sh;
                    mant_next = {mant_reg[48:0], 1'b0};
                end
            end
        end else if (cmd.prep) begin
            if ((cmd.op == OP_DIV || cmd.op == OP_SQRT) && rem_reg != 0) begin
                mant_next = {mant_reg[48:0], 1'b1};
                exp_next = exp_reg - 12'sd1;
            end
            nrm_next = msb50(mant_next);
        end else if (cmd.round) begin
            res_next = special_reg ? spec_val_reg : packed_v;
        end
    end

    always_ff @(posedge aclk) begin
        special_reg <= special_next;
        spec_val_reg <= spec_val_next;
        sign_reg <= sign_next;
        exp_reg <= exp_next;
        mant_reg <= mant_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        nrm_reg <= nrm_next;
        res_reg <= res_next;
    end

    assign stat.special = special_reg;
    assign stat.iter_done = (cmd.op == OP_DIV) ? (cnt_reg == 5'(ITER_N - 1))
                                                : (cnt_reg == 5'd25);
    assign result = res_reg;
endmodule
`default_nettype wire

>>> hdl/fac_control.sv
// Command sequencer: handshakes, error state and accumulator register
`timescale 1ns / 1ps
`default_nettype none
module fac_control (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [2:0]        cmd_in,
    input  wire logic [31:0]       operand_in,
    input  wire logic              last_in,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            value_out,
    output logic [1:0]             err_out,
    output logic                   last_out,
    output fac_pkg::dp_cmd_t       dp_cmd,
    input  wire fac_pkg::dp_stat_t dp_stat,
    input  wire logic [31:0]       dp_result,
    output logic [31:0]            acc_out,
    output logic [31:0]            opnd_out
);
    import fac_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  err_reg, err_next;
    logic [31:0] opnd_reg, opnd_next;
    op_t         op_reg, op_next;
    logic        last_reg, last_next;
    logic        ov_reg, ov_next;

    logic acc_nan, acc_neg;
    assign acc_nan = (acc_reg[30:23] == 8'hFF) && (acc_reg[22:0] != 0);
    assign acc_neg = acc_reg[31] && (acc_reg[30:0] != 0) && !acc_nan;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg <= 32'b0;
            err_reg <= ERR_NONE;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg <= acc_next;
            err_reg <= err_next;
            ov_reg <= ov_next;
        end
        opnd_reg <= opnd_next;
        op_reg <= op_next;
        last_reg <= last_next;
    end

    always_comb begin
        state_next = state_reg;
        acc_next = acc_reg;
        err_next = err_reg;
        opnd_next = opnd_reg;
        op_next = op_reg;
        last_next = last_reg;
        ov_next = ov_reg;
        dp_cmd = '{start: 1'b0, prep: 1'b0, iter: 1'b0, round: 1'b0, op: op_reg};
        s_tready = 1'b0;
        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_tready = !ov_reg || m_tready;
                if (s_tvalid && s_tready) begin
                    opnd_next = operand_in;
                    last_next = last_in;
                    if (cmd_in == CMD_LOAD) begin
                        acc_next = operand_in;
                        err_next = ERR_NONE;
                        ov_next = 1'b1;
                    end else if (err_reg != ERR_NONE || cmd_in > CMD_SQRT) begin
                        ov_next = 1'b1;
                    end else if (cmd_in == CMD_DIV && operand_in[30:0] == 0) begin
                        err_next = ERR_DIV0;
                        ov_next = 1'b1;
                    end else if (cmd_in == CMD_SQRT && acc_neg) begin
                        err_next = ERR_SQRT;
                        ov_next = 1'b1;
                    end else begin
                        case (cmd_in)
                            CMD_ADD: op_next = OP_ADD;
                            CMD_MUL: op_next = OP_MUL;
                            CMD_DIV: op_next = OP_DIV;
                            default: op_next = OP_SQRT;
                        endcase
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                dp_cmd.start = 1'b1;
                state_next = (op_reg == OP_DIV || op_reg == OP_SQRT) ? ST_ITER : ST_ROUND;
            end
            ST_ITER: begin
                dp_cmd.iter = 1'b1;
                if (dp_stat.iter_done) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                dp_cmd.prep = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                dp_cmd.round = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                acc_next = dp_result;
                ov_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign acc_out = acc_reg;
    assign opnd_out = opnd_reg;
    assign m_tvalid = ov_reg;
    assign value_out = acc_reg;
    assign err_out = err_reg;
    assign last_out = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accepted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (err_reg == ERR_NONE)) else $error("work under error");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(value_out)) else $error("result moved");
endmodule
`default_nettype wire

>>> hdl/float_accumulator_calculator.sv
// Top level of the binary32 accumulator calculator
//  channel | dir | tdata (low bit up)       | tuser | tlast
//  s_      | in  | cmd[2:0], operand[34:3] | -     | last_command
//  m_      | out | value[31:0], err[33:32]  | -     | final_result
// A load, an ignored or an erroring command answers in the cycle after its transfer.
// Add and multiply step through the PREP, ROUND, OUT and WB states; divide and square
// root also pass through ST_ITER, the one-bit-a-cycle iteration in the datapath. Reset is
// synchronous, active low, and clears accumulator and error. A stalled result
// holds s_tready low; the next command is taken in the cycle the result transfers.
`timescale 1ns / 1ps
`default_nettype none
module float_accumulator_calculator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // cmd, operand
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // value, error_code
    output logic             m_tlast
);
    import fac_pkg::*;

    dp_cmd_t     dp_cmd;
    dp_stat_t    dp_stat;
    logic [31:0] dp_result, acc, opnd, value;
    logic [1:0]  err;
    logic        s_ready_int;

    // hold the input until the rounded value is written back
    fac_control u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_ready_int),
        .cmd_in(s_tdata[2:0]), .operand_in(s_tdata[34:3]), .last_in(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .value_out(value), .err_out(err), .last_out(m_tlast),
        .dp_cmd(dp_cmd), .dp_stat(dp_stat), .dp_result(dp_result),
        .acc_out(acc), .opnd_out(opnd)
    );

    fac_datapath u_dp (
        .aclk(aclk), .cmd(dp_cmd), .a_in(acc), .b_in(opnd),
        .stat(dp_stat), .result(dp_result)
    );

    assign s_tready = s_ready_int;
    assign m_tdata = {6'b0, err, value};
endmodule
`default_nettype wire
